// ----- hw/rtl/tkcl_pkg.sv -----
// Shared types, constants and the ordering function of the top-k candidate list.
// Used by tkcl_cell and top_k_candidate_list; depends on nothing.
`default_nettype none
package tkcl_pkg;

  // Storage and field sizes
  localparam int MAX_ENTRIES = 16;
  localparam int NODE_BITS   = 20;
  localparam int AREA_BITS   = 16;
  localparam int DEPTH_BITS  = 8;
  localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
  localparam int LIMIT_BITS  = 5;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 5;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_LIST_LIMIT = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_AREA_FIRST = 1'd1;

  // Reset values
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd10;

  typedef struct packed {
    logic [NODE_BITS-1:0]  node;
    logic                  compl_bit;
    logic [AREA_BITS-1:0]  area;
    logic [DEPTH_BITS-1:0] depth;
  } entry_t;

  typedef struct packed {
    logic                  start_new;
    logic [NODE_BITS-1:0]  cand_node;
    logic                  cand_compl;
    logic [AREA_BITS-1:0]  cand_area;
    logic [DEPTH_BITS-1:0] cand_depth;
  } in_req_t;

  typedef struct packed {
    logic                  accepted;
    logic                  duplicate;
    logic [CNT_BITS-1:0]   entry_count;
    logic [NODE_BITS-1:0]  front_node;
    logic                  front_compl;
    logic [AREA_BITS-1:0]  front_area;
    logic [DEPTH_BITS-1:0] front_depth;
  } out_res_t;

  // Status rippling from cell to cell along the row
  typedef struct packed {
    logic all_better;   // every earlier kept entry beats the candidate
    logic dup;          // an earlier valid entry has the candidate's id
    logic last_better;  // candidate beats the last valid entry
  } chain_t;

  // Per-cell control from the top level
  typedef struct packed {
    logic in_fill;  // cell holds a valid entry
    logic in_cnt;   // cell is among the entries kept on insertion
    logic is_last;  // cell holds the last valid entry
    logic ins_en;   // insertion happens this cycle
  } cell_ctl_t;

  // True if a is strictly better than b under the selected order
  function automatic logic better(input entry_t a, input entry_t b, input logic area_first);
    logic res;
    if (area_first) begin
      res = (a.area < b.area) || ((a.area == b.area) && (a.depth < b.depth));
    end else begin
      res = (a.depth < b.depth) || ((a.depth == b.depth) && (a.area < b.area));
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tkcl_cell.sv -----
// One slot of the sorted candidate row: holds an entry, compares it with the
// candidate and shifts from its left neighbor on insertion. Uses tkcl_pkg.
`default_nettype none
module tkcl_cell (
  input  wire logic              clk,
  input  wire tkcl_pkg::entry_t  cand,
  input  wire logic              area_first,
  input  wire tkcl_pkg::cell_ctl_t ctl,
  input  wire tkcl_pkg::entry_t  prev_entry,
  input  wire tkcl_pkg::chain_t  chain_in,
  output tkcl_pkg::chain_t       chain_out,
  output tkcl_pkg::entry_t       entry_out
);

  tkcl_pkg::entry_t entry_r;
  tkcl_pkg::entry_t entry_nxt;
  logic             me_better;
  logic             cand_better;
  logic             id_match;
  logic             ins_here;

  // Local compares against the broadcast candidate
  assign me_better   = tkcl_pkg::better(entry_r, cand, area_first);
  assign cand_better = tkcl_pkg::better(cand, entry_r, area_first);
  assign id_match    = (entry_r.node == cand.node) && (entry_r.compl_bit == cand.compl_bit);

  // First slot that is not a kept entry beating the candidate takes it
  assign ins_here = chain_in.all_better && !(ctl.in_cnt && me_better);

  // Status toward the right neighbor
  always_comb begin
    chain_out.all_better  = chain_in.all_better && ctl.in_cnt && me_better;
    chain_out.dup         = chain_in.dup || (ctl.in_fill && id_match);
    chain_out.last_better = chain_in.last_better || (ctl.is_last && cand_better);
  end

  // Insert or shift right
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins_en) begin
      if (ins_here) begin
        entry_nxt = cand;
      end else if (!chain_in.all_better) begin
        entry_nxt = prev_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_out = entry_r;

endmodule
`default_nettype wire

// ----- hw/rtl/top_k_candidate_list.sv -----
// Top level of the bounded sorted top-k candidate list: control, configuration
// registers and the row of tkcl_cell slots. Uses tkcl_pkg and tkcl_cell.
`default_nettype none
// A request is taken at a clock edge with start high and busy low. The next
// cycle busy is high while the cell row compares the candidate with every kept
// entry and inserts it if accepted, in one shift of the row; in the cycle after
// that out_valid is high for exactly one cycle with the result, and start may
// be taken again in that same cycle. A request is handled by a single
// compare-and-shift pass through the row. The receiver cannot stall:
// out_result is only valid while out_valid is high. Configuration writes land
// at once and must be made only while no request is in flight.
module top_k_candidate_list (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire tkcl_pkg::in_req_t                     in_req,
  output logic                                       out_valid,
  output tkcl_pkg::out_res_t                         out_result,
  input  wire logic                                  cfg_we,
  input  wire logic [tkcl_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [tkcl_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

  localparam int N  = tkcl_pkg::MAX_ENTRIES;
  localparam int CW = tkcl_pkg::CNT_BITS;

  logic [tkcl_pkg::LIMIT_BITS-1:0] list_limit_r;
  logic                            area_first_r;
  logic                            busy_r;
  logic                            out_valid_r;
  logic                            acc_r;
  logic                            acc_nxt;
  logic                            dup_r;
  logic [CW-1:0]                   fill_r;
  logic [CW-1:0]                   fill_nxt;
  logic [CW-1:0]                   lim;
  logic [CW-1:0]                   kept;
  logic                            full;
  logic                            accept;
  tkcl_pkg::entry_t                cand_r;
  tkcl_pkg::chain_t                chain [N+1];
  tkcl_pkg::entry_t                ents  [N];
  tkcl_pkg::cell_ctl_t             ctl   [N];

  assign accept = start && !busy_r;

  // Effective limit, clamped to 1..MAX_ENTRIES
  always_comb begin
    if (list_limit_r == '0) begin
      lim = CW'(1);
    end else if (CW'(list_limit_r) > CW'(N)) begin
      lim = CW'(N);
    end else begin
      lim = CW'(list_limit_r);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_limit_r <= tkcl_pkg::LIMIT_RESET;
      area_first_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        tkcl_pkg::REG_LIST_LIMIT: list_limit_r <= cfg_wdata[tkcl_pkg::LIMIT_BITS-1:0];
        tkcl_pkg::REG_AREA_FIRST: area_first_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Capture the candidate
  always_ff @(posedge clk) begin
    if (accept) begin
      cand_r.node      <= in_req.cand_node;
      cand_r.compl_bit <= in_req.cand_compl;
      cand_r.area      <= in_req.cand_area;
      cand_r.depth     <= in_req.cand_depth;
    end
  end

  // Fill is already cut to the limit when busy
  assign full = (fill_r == lim);
  assign kept = full ? fill_r - CW'(1) : fill_r;

  // Per-cell control
  always_comb begin
    for (int i = 0; i < N; i++) begin
      ctl[i].in_fill = (CW'(i) < fill_r);
      ctl[i].in_cnt  = (CW'(i) < kept);
      ctl[i].is_last = (CW'(i + 1) == fill_r);
      ctl[i].ins_en  = busy_r && acc_nxt;
    end
  end

  assign chain[0] = '{all_better: 1'b1, dup: 1'b0, last_better: 1'b0};
  assign acc_nxt  = !chain[N].dup && (!full || chain[N].last_better);

  // Row of cells
  for (genvar g = 0; g < N; g++) begin : g_cell
    tkcl_cell u_cell (
      .clk        (clk),
      .cand       (cand_r),
      .area_first (area_first_r),
      .ctl        (ctl[g]),
      .prev_entry ((g == 0) ? cand_r : ents[(g == 0) ? 0 : g - 1]),
      .chain_in   (chain[g]),
      .chain_out  (chain[g+1]),
      .entry_out  (ents[g])
    );
  end

  // Fill count: cleared or cut to the limit on accept, grow on insertion into a non-full list
  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      if (in_req.start_new) begin
        fill_nxt = '0;
      end else if (fill_r > lim) begin
        fill_nxt = lim;
      end
    end else if (busy_r && acc_nxt && !full) begin
      fill_nxt = fill_r + CW'(1);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      busy_r      <= accept;
      out_valid_r <= busy_r;
    end
  end

  // Result flags
  always_ff @(posedge clk) begin
    if (busy_r) begin
      acc_r <= acc_nxt;
      dup_r <= chain[N].dup;
    end
  end

  // Result drive; front entry read from the first cell, zero when the list is empty
  always_comb begin
    out_result.accepted    = acc_r;
    out_result.duplicate   = dup_r;
    out_result.entry_count = fill_r;
    if (fill_r != '0) begin
      out_result.front_node  = ents[0].node;
      out_result.front_compl = ents[0].compl_bit;
      out_result.front_area  = ents[0].area;
      out_result.front_depth = ents[0].depth;
    end else begin
      out_result.front_node  = '0;
      out_result.front_compl = 1'b0;
      out_result.front_area  = '0;
      out_result.front_depth = '0;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire
